FILE: rtl/assert_macros.svh
// assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_HOLDS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_IMPLIES(lbl, ante, cons)

`define ASSERT_HOLDS_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/ffd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

    localparam int KEY_MAX_BYTES = 8;
    localparam int KEY_IDX_W     = 3;
    localparam int KEY_POS_MAX   = 15;
    localparam int VALUE_MAX_RAW = 127;
    localparam int RAW_CNT_W     = $clog2(VALUE_MAX_RAW + 1);
    localparam int MAX_RESULTS   = 4;
    localparam int REC_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH   = 8;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CHARS  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 8'd1;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_SKIP  = 2'd1,
        PH_VALUE = 2'd2,
        PH_TAIL  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_PERCENT = 2'd1,
        ESC_DIGIT   = 2'd2
    } esc_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } char_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       has_byte;
        logic       found;
        logic       done_res;
    } res_item_t;

    typedef struct packed {
        logic [REC_CNT_W-1:0]               n;
        res_item_t [MAX_RESULTS-1:0]        r;
    } rec_list_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic rec_list_t list_add(input rec_list_t l, input res_item_t it);
        rec_list_t o;
        o = l;
        if (l.n < REC_CNT_W'(MAX_RESULTS))
        begin
            o.r[l.n[$clog2(MAX_RESULTS)-1:0]] = it;
            o.n = l.n + REC_CNT_W'(1);
        end
        return o;
    endfunction

    function automatic res_item_t mk_byte(input logic [7:0] b);
        res_item_t o;
        o.value_byte = b;
        o.has_byte   = 1'b1;
        o.found      = 1'b0;
        o.done_res   = 1'b0;
        return o;
    endfunction

    function automatic res_item_t mk_done(input logic f);
        res_item_t o;
        o.value_byte = 8'h00;
        o.has_byte   = 1'b0;
        o.found      = f;
        o.done_res   = 1'b1;
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ffd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ffd_parser (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_stall,
    input  wire ffd_pkg::char_item_t    char_item,
    input  wire logic [63:0]            key_chars,
    input  wire logic [3:0]             key_length,
    input  wire logic                   room,
    output ffd_pkg::rec_list_t          push
);

    logic                               in_vld_reg;
    ffd_pkg::char_item_t                in_item_reg;
    logic                               fire;

    ffd_pkg::phase_t                    phase_reg, phase_next;
    logic                               ksm_reg, ksm_next;
    logic [3:0]                         kpos_reg, kpos_next;
    logic [ffd_pkg::RAW_CNT_W-1:0]      rcnt_reg, rcnt_next;
    ffd_pkg::esc_t                      esc_reg, esc_next;
    logic [7:0]                         held_reg, held_next;
    logic                               answered_reg, answered_next;

    logic [7:0]                         c;
    logic                               last;
    logic [3:0]                         klen;
    logic [ffd_pkg::RAW_CNT_W:0]        rcnt_sum;
    logic [7:0]                         dec;
    logic                               handled;
    logic                               zero_end;
    ffd_pkg::rec_list_t                 l;

    assign fire       = in_vld_reg && room;
    assign char_stall = in_vld_reg && !room;
    assign c          = in_item_reg.in_byte;
    assign last       = in_item_reg.in_last;
    assign klen       = (key_length > 4'(ffd_pkg::KEY_MAX_BYTES))
                        ? 4'(ffd_pkg::KEY_MAX_BYTES) : key_length;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (char_valid && !char_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_item_reg <= char_item;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        ksm_next      = ksm_reg;
        kpos_next     = kpos_reg;
        rcnt_next     = rcnt_reg;
        esc_next      = esc_reg;
        held_next     = held_reg;
        answered_next = answered_reg;
        rcnt_sum      = {1'b0, rcnt_reg} + (ffd_pkg::RAW_CNT_W + 1)'(1);
        dec           = {ffd_pkg::hex_val(held_reg), ffd_pkg::hex_val(c)};
        handled       = 1'b0;
        zero_end      = 1'b0;
        l             = '0;

        if (fire)
        begin
            if (!answered_reg)
            begin
                unique case (phase_reg)
                    ffd_pkg::PH_KEY:
                    begin
                        if (c == ffd_pkg::CH_NUL)
                        begin
                            l             = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b0));
                            answered_next = 1'b1;
                            phase_next    = ffd_pkg::PH_TAIL;
                        end
                        else if (c == ffd_pkg::CH_EQUAL)
                        begin
                            if (ksm_reg && kpos_reg == klen && klen != 4'd0)
                            begin
                                phase_next = ffd_pkg::PH_VALUE;
                                rcnt_next  = '0;
                                esc_next   = ffd_pkg::ESC_NONE;
                                held_next  = 8'h00;
                            end
                            else
                            begin
                                phase_next = ffd_pkg::PH_SKIP;
                            end
                        end
                        else if (c == ffd_pkg::CH_AMP)
                        begin
                            ksm_next  = 1'b1;
                            kpos_next = 4'd0;
                        end
                        else
                        begin
                            if (kpos_reg < klen)
                            begin
                                if (key_chars[8*kpos_reg[ffd_pkg::KEY_IDX_W-1:0] +: 8] != c)
                                begin
                                    ksm_next = 1'b0;
                                end
                            end
                            else
                            begin
                                ksm_next = 1'b0;
                            end
                            if (kpos_reg < 4'(ffd_pkg::KEY_POS_MAX))
                            begin
                                kpos_next = kpos_reg + 4'd1;
                            end
                        end
                    end
                    ffd_pkg::PH_SKIP:
                    begin
                        if (c == ffd_pkg::CH_NUL)
                        begin
                            l             = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b0));
                            answered_next = 1'b1;
                            phase_next    = ffd_pkg::PH_TAIL;
                        end
                        else if (c == ffd_pkg::CH_AMP)
                        begin
                            phase_next = ffd_pkg::PH_KEY;
                            ksm_next   = 1'b1;
                            kpos_next  = 4'd0;
                        end
                    end
                    ffd_pkg::PH_VALUE:
                    begin
                        if (c == ffd_pkg::CH_NUL || c == ffd_pkg::CH_AMP)
                        begin
                            if (esc_reg != ffd_pkg::ESC_NONE)
                            begin
                                l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(ffd_pkg::CH_PERCENT));
                            end
                            if (esc_reg == ffd_pkg::ESC_DIGIT)
                            begin
                                l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(held_reg));
                            end
                            esc_next      = ffd_pkg::ESC_NONE;
                            held_next     = 8'h00;
                            l             = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b1));
                            answered_next = 1'b1;
                            phase_next    = ffd_pkg::PH_TAIL;
                        end
                        else
                        begin
                            rcnt_next = rcnt_sum[ffd_pkg::RAW_CNT_W-1:0];
                            if (esc_reg == ffd_pkg::ESC_PERCENT)
                            begin
                                if (ffd_pkg::is_hex(c))
                                begin
                                    held_next = c;
                                    esc_next  = ffd_pkg::ESC_DIGIT;
                                    handled   = 1'b1;
                                end
                                else
                                begin
                                    l = ffd_pkg::list_add(l,
                                        ffd_pkg::mk_byte(ffd_pkg::CH_PERCENT));
                                    esc_next  = ffd_pkg::ESC_NONE;
                                    held_next = 8'h00;
                                end
                            end
                            else if (esc_reg == ffd_pkg::ESC_DIGIT)
                            begin
                                esc_next  = ffd_pkg::ESC_NONE;
                                held_next = 8'h00;
                                if (ffd_pkg::is_hex(c))
                                begin
                                    handled = 1'b1;
                                    if (dec == 8'h00)
                                    begin
                                        zero_end = 1'b1;
                                    end
                                    else
                                    begin
                                        l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(dec));
                                    end
                                end
                                else
                                begin
                                    l = ffd_pkg::list_add(l,
                                        ffd_pkg::mk_byte(ffd_pkg::CH_PERCENT));
                                    l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(held_reg));
                                end
                            end
                            if (!handled)
                            begin
                                if (c == ffd_pkg::CH_PLUS)
                                begin
                                    l = ffd_pkg::list_add(l,
                                        ffd_pkg::mk_byte(ffd_pkg::CH_SPACE));
                                end
                                else if (c == ffd_pkg::CH_PERCENT)
                                begin
                                    esc_next = ffd_pkg::ESC_PERCENT;
                                end
                                else
                                begin
                                    l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(c));
                                end
                            end
                            if (zero_end)
                            begin
                                l             = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b1));
                                answered_next = 1'b1;
                                phase_next    = ffd_pkg::PH_TAIL;
                            end
                            else if (rcnt_sum >= (ffd_pkg::RAW_CNT_W + 1)'(ffd_pkg::VALUE_MAX_RAW))
                            begin
                                if (esc_next != ffd_pkg::ESC_NONE)
                                begin
                                    l = ffd_pkg::list_add(l,
                                        ffd_pkg::mk_byte(ffd_pkg::CH_PERCENT));
                                end
                                if (esc_next == ffd_pkg::ESC_DIGIT)
                                begin
                                    l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(held_next));
                                end
                                esc_next      = ffd_pkg::ESC_NONE;
                                held_next     = 8'h00;
                                l             = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b1));
                                answered_next = 1'b1;
                                phase_next    = ffd_pkg::PH_TAIL;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // end of string with no answer yet
                if (last && !answered_next)
                begin
                    if (phase_next == ffd_pkg::PH_VALUE)
                    begin
                        if (esc_next != ffd_pkg::ESC_NONE)
                        begin
                            l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(ffd_pkg::CH_PERCENT));
                        end
                        if (esc_next == ffd_pkg::ESC_DIGIT)
                        begin
                            l = ffd_pkg::list_add(l, ffd_pkg::mk_byte(held_next));
                        end
                        l = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b1));
                    end
                    else
                    begin
                        l = ffd_pkg::list_add(l, ffd_pkg::mk_done(1'b0));
                    end
                    answered_next = 1'b1;
                end
            end

            if (last)
            begin
                phase_next    = ffd_pkg::PH_KEY;
                ksm_next      = 1'b1;
                kpos_next     = 4'd0;
                rcnt_next     = '0;
                esc_next      = ffd_pkg::ESC_NONE;
                held_next     = 8'h00;
                answered_next = 1'b0;
            end
        end
    end

    assign push = l;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ffd_pkg::PH_KEY;
            ksm_reg      <= 1'b1;
            kpos_reg     <= 4'd0;
            rcnt_reg     <= '0;
            esc_reg      <= ffd_pkg::ESC_NONE;
            held_reg     <= 8'h00;
            answered_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ksm_reg      <= ksm_next;
            kpos_reg     <= kpos_next;
            rcnt_reg     <= rcnt_next;
            esc_reg      <= esc_next;
            held_reg     <= held_next;
            answered_reg <= answered_next;
        end
    end

    `ASSERT_IMPLIES(tail_when_answered, answered_reg, phase_reg == ffd_pkg::PH_TAIL)

endmodule

`default_nettype wire

FILE: rtl/ffd_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ffd_result_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ffd_pkg::rec_list_t     push,
    output logic                        room,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output ffd_pkg::res_item_t          res_item
);

    ffd_pkg::res_item_t                 mem [ffd_pkg::QUEUE_DEPTH];
    logic [ffd_pkg::QUEUE_AW-1:0]       head_reg, tail_reg;
    logic [ffd_pkg::QUEUE_AW:0]         count_reg, count_next;
    logic                               pop;

    assign res_valid = count_reg != '0;
    assign res_item  = mem[head_reg];
    assign pop       = res_valid && !res_stall;
    assign room      = count_reg <= (ffd_pkg::QUEUE_AW + 1)'(ffd_pkg::QUEUE_DEPTH
                                                              - ffd_pkg::MAX_RESULTS);
    assign count_next = count_reg + (ffd_pkg::QUEUE_AW + 1)'(push.n)
                        - (ffd_pkg::QUEUE_AW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ffd_pkg::MAX_RESULTS; k++)
        begin
            if (ffd_pkg::REC_CNT_W'(k) < push.n)
            begin
                mem[tail_reg + ffd_pkg::QUEUE_AW'(k)] <= push.r[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + ffd_pkg::QUEUE_AW'(pop);
            tail_reg  <= tail_reg + ffd_pkg::QUEUE_AW'(push.n);
            count_reg <= count_next;
        end
    end

    `ASSERT_ALWAYS(count_in_range, count_reg <= (ffd_pkg::QUEUE_AW + 1)'(ffd_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLIES(push_needs_room, push.n != '0, room)
    `ASSERT_HOLDS_NEXT(head_held_on_stall, res_valid && res_stall, $stable(head_reg))

endmodule

`default_nettype wire

FILE: rtl/form_field_extract_decode_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Form field extractor: takes one character of an ampersand-separated
// key=value string per item and streams out the URL-decoded value of the
// first segment whose key equals key_chars/key_length, then one terminal
// item with found set or clear. A character is taken every clock unless
// stalled; its results pass the input register and the eight-entry result
// queue. A character yields up to four result items, which leave the queue one
// per clock while res_stall is low; char_stall rises while a character waits
// and that queue has fewer than four free entries, so the sustained rate is
// one character per clock as long as the characters average at most one result
// each and res_stall stays low. Configuration writes are always ready and must
// be made only while the block is idle.

module form_field_extract_decode_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               char_valid,
    output logic                                    char_stall,
    input  wire ffd_pkg::char_item_t                char_item,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output ffd_pkg::res_item_t                      res_item,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ffd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [63:0]                        cfg_data
);

    logic [63:0]            key_chars_reg;
    logic [3:0]             key_length_reg;
    logic                   room;
    ffd_pkg::rec_list_t     push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= 64'd0;
            key_length_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ffd_pkg::CFG_KEY_CHARS:  key_chars_reg  <= cfg_data;
                ffd_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    ffd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .key_chars  (key_chars_reg),
        .key_length (key_length_reg),
        .room       (room),
        .push       (push)
    );

    ffd_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

endmodule

`default_nettype wire

FILE: sim/ffd_checker.sv
`timescale 1ns / 1ps

module ffd_checker
    import ffd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    input  logic                   char_stall,
    input  char_item_t             char_item,
    input  logic                   res_valid,
    input  logic                   res_stall,
    input  res_item_t              res_item,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output int                     fail_count,
    output int                     pending
);

    logic [63:0] key_word;
    logic [3:0]  key_count;

    phase_t      scan_phase;
    logic        key_alive;
    logic [3:0]  key_at;
    int          raw_seen;
    esc_t        esc_state;
    logic [7:0]  first_digit;
    logic        answered;

    res_item_t   decoded_due[$];
    int          errors;

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    // digits carry their value in the low nibble, letters are off by nine
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    task automatic start_string();
        scan_phase  = PH_KEY;
        key_alive   = 1'b1;
        key_at      = 4'd0;
        raw_seen    = 0;
        esc_state   = ESC_NONE;
        first_digit = 8'h00;
        answered    = 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        res_item_t r;
        r.value_byte = b;
        r.has_byte   = 1'b1;
        r.found      = 1'b0;
        r.done_res   = 1'b0;
        decoded_due.push_back(r);
    endtask

    task automatic give_answer(input logic f);
        res_item_t r;
        r.value_byte = 8'h00;
        r.has_byte   = 1'b0;
        r.found      = f;
        r.done_res   = 1'b1;
        decoded_due.push_back(r);
        answered   = 1'b1;
        scan_phase = PH_TAIL;
    endtask

    // an unfinished escape comes out as literal characters
    task automatic flush_escape();
        if (esc_state != ESC_NONE)
        begin
            push_byte(CH_PERCENT);
        end
        if (esc_state == ESC_DIGIT)
        begin
            push_byte(first_digit);
        end
        esc_state   = ESC_NONE;
        first_digit = 8'h00;
    endtask

    task automatic decode_char(input char_item_t item);
        logic [7:0] c;
        logic [7:0] v;
        logic [3:0] klen;
        logic       taken;
        logic       zero_end;
        c = item.in_byte;
        klen = (key_count > KEY_MAX_BYTES) ? 4'(KEY_MAX_BYTES) : key_count;
        if (!answered)
        begin
            case (scan_phase)
                PH_KEY:
                begin
                    if (c == CH_NUL)
                    begin
                        give_answer(1'b0);
                    end
                    else if (c == CH_EQUAL)
                    begin
                        if (key_alive && key_at == klen && klen != 4'd0)
                        begin
                            scan_phase  = PH_VALUE;
                            raw_seen    = 0;
                            esc_state   = ESC_NONE;
                            first_digit = 8'h00;
                        end
                        else
                        begin
                            scan_phase = PH_SKIP;
                        end
                    end
                    else if (c == CH_AMP)
                    begin
                        key_alive = 1'b1;
                        key_at    = 4'd0;
                    end
                    else
                    begin
                        if (key_at >= klen || 8'(key_word >> (8 * key_at)) != c)
                        begin
                            key_alive = 1'b0;
                        end
                        if (key_at < KEY_POS_MAX)
                        begin
                            key_at++;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (c == CH_NUL)
                    begin
                        give_answer(1'b0);
                    end
                    else if (c == CH_AMP)
                    begin
                        scan_phase = PH_KEY;
                        key_alive  = 1'b1;
                        key_at     = 4'd0;
                    end
                end
                PH_VALUE:
                begin
                    if (c == CH_NUL || c == CH_AMP)
                    begin
                        flush_escape();
                        give_answer(1'b1);
                    end
                    else
                    begin
                        raw_seen++;
                        taken    = 1'b0;
                        zero_end = 1'b0;
                        if (esc_state == ESC_PERCENT)
                        begin
                            if (is_hex_char(c))
                            begin
                                first_digit = c;
                                esc_state   = ESC_DIGIT;
                                taken       = 1'b1;
                            end
                            else
                            begin
                                flush_escape();
                            end
                        end
                        else if (esc_state == ESC_DIGIT)
                        begin
                            if (is_hex_char(c))
                            begin
                                v = {nibble_of(first_digit), nibble_of(c)};
                                esc_state   = ESC_NONE;
                                first_digit = 8'h00;
                                taken       = 1'b1;
                                if (v == 8'h00)
                                begin
                                    zero_end = 1'b1;
                                end
                                else
                                begin
                                    push_byte(v);
                                end
                            end
                            else
                            begin
                                flush_escape();
                            end
                        end
                        if (!taken)
                        begin
                            if (c == CH_PLUS)
                            begin
                                push_byte(CH_SPACE);
                            end
                            else if (c == CH_PERCENT)
                            begin
                                esc_state = ESC_PERCENT;
                            end
                            else
                            begin
                                push_byte(c);
                            end
                        end
                        if (zero_end)
                        begin
                            give_answer(1'b1);
                        end
                        else if (raw_seen >= VALUE_MAX_RAW)
                        begin
                            flush_escape();
                            give_answer(1'b1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (item.in_last && !answered)
            begin
                if (scan_phase == PH_VALUE)
                begin
                    flush_escape();
                    give_answer(1'b1);
                end
                else
                begin
                    give_answer(1'b0);
                end
            end
        end
        if (item.in_last)
        begin
            start_string();
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_item_t want;
        if (!rst_n)
        begin
            key_word  = '0;
            key_count = 4'd1;
            start_string();
            decoded_due.delete();
            errors = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEY_CHARS)
                begin
                    key_word = cfg_data;
                end
                else if (cfg_index == CFG_KEY_LENGTH)
                begin
                    key_count = cfg_data[3:0];
                end
            end
            if (res_valid && !res_stall)
            begin
                if (decoded_due.size() == 0)
                begin
                    $display("%0t: expected no item, got byte %0h has %0b found %0b done %0b",
                             $time, res_item.value_byte, res_item.has_byte,
                             res_item.found, res_item.done_res);
                    errors++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    check_field("value_byte", want.value_byte, res_item.value_byte);
                    check_field("has_byte", 8'(want.has_byte), 8'(res_item.has_byte));
                    check_field("found", 8'(want.found), 8'(res_item.found));
                    check_field("done_res", 8'(want.done_res), 8'(res_item.done_res));
                end
            end
            if (char_valid && !char_stall)
            begin
                decode_char(char_item);
            end
            pending    <= decoded_due.size();
            fail_count <= errors;
        end
    end

endmodule

FILE: sim/tb_form_field_extract_decode_top.sv
`timescale 1ns / 1ps

module tb_form_field_extract_decode_top;
    import ffd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'hA5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   char_valid = 1'b0;
    logic                   char_stall;
    char_item_t             char_item  = '0;
    logic                   res_valid;
    logic                   res_stall  = 1'b0;
    res_item_t              res_item;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [63:0]            cfg_data   = '0;
    int                     fail_count;
    int                     pending;

    int                     gap_pct       = 0;
    int                     stall_pct     = 0;
    int                     hold_requests = 0;
    logic [63:0]            key_word      = '0;
    logic [3:0]             key_count     = 4'd1;
    logic [7:0]             text[$];

    always #5 clk = ~clk;

    form_field_extract_decode_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    ffd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("form_field_extract_decode_top: mismatch");
        $finish;
    end

    function automatic logic [7:0] word_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(8'h30, 8'h39));
            1:       return 8'($urandom_range(8'h41, 8'h5a));
            default: return 8'($urandom_range(8'h61, 8'h7a));
        endcase
    endfunction

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(21);
        if (n < 10)
        begin
            return 8'(8'h30 + n);
        end
        if (n < 16)
        begin
            return 8'(8'h61 + n - 10);
        end
        return 8'(8'h41 + n - 16);
    endfunction

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++)
        begin
            k[8*i +: 8] = word_char();
        end
        return k;
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
    endtask

    task automatic send_char(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < gap_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= '{in_byte: b, in_last: l};
        @(posedge clk);
        while (char_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
        begin
            send_char(text[i], i == text.size() - 1);
        end
        text.delete();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_key(input logic [63:0] chars, input logic [3:0] len);
        write_reg(CFG_KEY_CHARS, chars);
        write_reg(CFG_KEY_LENGTH, {60'd0, len});
        cfg_valid <= 1'b0;
        key_word  = chars;
        key_count = len;
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly key=value segments around the configured key, some raw noise
    task automatic make_text(input bit long_value);
        int nseg;
        int kind;
        int klen;
        int vlen;
        int start;
        klen = (key_count > KEY_MAX_BYTES) ? KEY_MAX_BYTES : key_count;
        if (!long_value && $urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(255)));
            return;
        end
        nseg = long_value ? 1 : $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++)
        begin
            if (s > 0)
            begin
                text.push_back(CH_AMP);
            end
            kind = long_value ? 0 : $urandom_range(9);
            if (kind <= 4 || kind == 6)
            begin
                for (int i = 0; i < klen; i++)
                begin
                    text.push_back(8'(key_word >> (8 * i)));
                end
                if (kind == 6)
                begin
                    text.push_back(word_char());
                end
            end
            else if (kind == 5 || kind == 8)
            begin
                for (int i = 0; i < klen - 1; i++)
                begin
                    text.push_back(8'(key_word >> (8 * i)));
                end
                if (kind == 8)
                begin
                    text.push_back(word_char());
                end
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 4)) text.push_back(word_char());
            end
            if (long_value || $urandom_range(7) != 0)
            begin
                text.push_back(CH_EQUAL);
            end
            vlen  = long_value ? 130 : $urandom_range(0, 6);
            start = text.size();
            while (text.size() - start < vlen)
            begin
                case (long_value ? $urandom_range(7) : $urandom_range(11))
                    0, 1, 2: text.push_back(word_char());
                    3:       text.push_back(CH_PLUS);
                    4:
                    begin
                        text.push_back(CH_PERCENT);
                        text.push_back(hex_char());
                        text.push_back(hex_char());
                    end
                    5:
                    begin
                        text.push_back(CH_PERCENT);
                        text.push_back(hex_char());
                        text.push_back(8'($urandom_range(8'h67, 8'h7a)));
                    end
                    6:       text.push_back(CH_PERCENT);
                    7:
                    begin
                        text.push_back(CH_PERCENT);
                        text.push_back(hex_char());
                    end
                    8:       text.push_back(8'($urandom_range(1, 255)));
                    9:
                    begin
                        text.push_back(CH_PERCENT);
                        text.push_back(8'h30);
                        text.push_back(8'h30);
                    end
                    10:      text.push_back(CH_NUL);
                    default: text.push_back(CH_AMP);
                endcase
            end
        end
        if ($urandom_range(5) == 0)
        begin
            repeat ($urandom_range(1, 3)) text.push_back(word_char());
        end
    endtask

    task automatic random_phase(input int gap, input int stall, input int budget,
                                input bit with_hold);
        int sent;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        if (with_hold)
        begin
            hold_requests++;
            make_text(1'b1);
            sent += text.size();
            send_text();
        end
        while (sent < budget)
        begin
            make_text(1'b0);
            sent += text.size();
            send_text();
        end
        settle();
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_key(64'h6b, 4'd1);
        // skipped segment, then a value ending in a half escape
        add_str("x&k=%2");
        send_text();
        // plus, hex escape, decoded zero ends the value, tail ignored
        add_str("k=+%4a%00z");
        send_text();
        // raw zero in the key
        text.push_back(8'hFF);
        text.push_back(CH_NUL);
        add_str("x");
        send_text();
        // value cut at the ampersand
        add_str("k=");
        text.push_back(8'hFF);
        add_str("&q");
        send_text();
        // string ends inside the key
        add_str("k");
        send_text();
        settle();

        set_key(rand_key(), 4'd8);
        random_phase(0, 0, 12, 1'b0);

        write_reg(CFG_UNUSED, 64'h0123_4567_89ab_cdef);
        set_key(64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
        random_phase(65, 0, 12, 1'b0);

        set_key(rand_key(), 4'd3);
        random_phase(0, 65, 0, 1'b1);

        set_key(rand_key(), 4'd15);
        random_phase(35, 35, 12, 1'b0);

        set_key(64'h0, 4'd0);
        random_phase(35, 35, 8, 1'b0);

        if (fail_count == 0 && pending == 0)
        begin
            $display("form_field_extract_decode_top: match");
        end
        else
        begin
            $display("form_field_extract_decode_top: mismatch");
        end
        $finish;
    end

endmodule
